// File: src/aesp_pkg.sv
// Shared types and constants for the escape sequence parser.
// No dependencies; used by every module in the block by scoped names.
`default_nettype none

package aesp_pkg;

   // Parser sizing
   localparam int MAX_PARAMS  = 4;
   localparam int PARAM_BITS  = 16;
   localparam int IDX_W       = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int CNT_W       = $clog2(MAX_PARAMS + 1);
   localparam int RSP_PARAMS  = 4;
   localparam int COUNT_BITS  = 3;
   // times-ten accumulate needs four bits of headroom before saturation
   localparam int ACC_W       = PARAM_BITS + 4;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths
   localparam int RSP_FIELD_BITS = 8 + 8 + 1 + COUNT_BITS + RSP_PARAMS * PARAM_BITS;
   localparam int RSP_DATA_W     = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_W     = 5;

   // Byte codes
   localparam logic [7:0] CH_BEL  = 8'h07;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_HT   = 8'h09;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SO   = 8'h0E;
   localparam logic [7:0] CH_SI   = 8'h0F;
   localparam logic [7:0] CH_CAN  = 8'h18;
   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_DEL  = 8'h7F;
   localparam logic [7:0] CH_CSI  = 8'h9B;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_QUES = 8'h3F;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // Action codes reported with each result
   typedef enum logic [3:0] {
      ACT_NONE      = 4'd0,
      ACT_BEEP      = 4'd1,
      ACT_BACKSPACE = 4'd2,
      ACT_TAB       = 4'd3,
      ACT_LF        = 4'd4,
      ACT_CR        = 4'd5,
      ACT_DEL       = 4'd6,
      ACT_ESC_ESC   = 4'd7,
      ACT_CSI       = 4'd8
   } action_type;

   // What an escape final does
   typedef enum logic [1:0] {
      ESC_OPEN_CSI = 2'd0,
      ESC_SKIP     = 2'd1,
      ESC_OSC      = 2'd2,
      ESC_CLOSE    = 2'd3
   } esc_op_type;

   // Classified byte, as queued between front and back
   typedef struct packed {
      logic [7:0] data;
      logic       ctrl;        // in the idle control byte set
      action_type ctrl_action;
      logic       esc;         // ESC byte
      logic       csi_intro;   // single byte CSI
      logic       esc_final;
      esc_op_type esc_op;
      logic       csi_final;
      logic       mode_final;  // h or l, needs the private flag
      logic       question;
      logic       semi;
      logic       digit;
      logic [3:0] digit_val;
   } item_type;

   // One result
   typedef struct packed {
      logic                                   show;
      action_type                             action;
      logic [7:0]                             data;
      logic [7:0]                             final_code;
      logic                                   private_mode;
      logic [COUNT_BITS-1:0]                  param_count;
      logic [RSP_PARAMS-1:0][PARAM_BITS-1:0]  params;
   } result_type;

endpackage

`default_nettype wire

// File: src/aesp_front.sv
// Front end: classifies each incoming byte into flags for the back end.
// Depends on aesp_pkg.
`default_nettype none

module aesp_front (
   input  wire logic [7:0]        byte_in,
   output aesp_pkg::item_type     item_out
);

   // Per-byte decode, independent of parser state
   always_comb begin
      item_out             = '0;
      item_out.data        = byte_in;
      item_out.ctrl_action = aesp_pkg::ACT_NONE;
      item_out.esc_op      = aesp_pkg::ESC_CLOSE;

      // control bytes acted on only when no sequence is open
      case (byte_in)
         aesp_pkg::CH_BEL: begin
            item_out.ctrl = 1'b1;
            item_out.ctrl_action = aesp_pkg::ACT_BEEP;
         end
         aesp_pkg::CH_BS: begin
            item_out.ctrl = 1'b1;
            item_out.ctrl_action = aesp_pkg::ACT_BACKSPACE;
         end
         aesp_pkg::CH_HT: begin
            item_out.ctrl = 1'b1;
            item_out.ctrl_action = aesp_pkg::ACT_TAB;
         end
         aesp_pkg::CH_LF: begin
            item_out.ctrl = 1'b1;
            item_out.ctrl_action = aesp_pkg::ACT_LF;
         end
         aesp_pkg::CH_CR: begin
            item_out.ctrl = 1'b1;
            item_out.ctrl_action = aesp_pkg::ACT_CR;
         end
         aesp_pkg::CH_DEL: begin
            item_out.ctrl = 1'b1;
            item_out.ctrl_action = aesp_pkg::ACT_DEL;
         end
         aesp_pkg::CH_SO, aesp_pkg::CH_SI, aesp_pkg::CH_CAN: begin
            item_out.ctrl = 1'b1;
         end
         aesp_pkg::CH_ESC: begin
            item_out.ctrl = 1'b1;
            item_out.esc  = 1'b1;
         end
         aesp_pkg::CH_CSI: begin
            item_out.ctrl      = 1'b1;
            item_out.csi_intro = 1'b1;
         end
         default: begin
            item_out.ctrl = 1'b0;
         end
      endcase

      // escape finals
      case (byte_in)
         "[": begin
            item_out.esc_final = 1'b1;
            item_out.esc_op    = aesp_pkg::ESC_OPEN_CSI;
         end
         "%", "#", "(", ")": begin
            item_out.esc_final = 1'b1;
            item_out.esc_op    = aesp_pkg::ESC_SKIP;
         end
         "]": begin
            item_out.esc_final = 1'b1;
            item_out.esc_op    = aesp_pkg::ESC_OSC;
         end
         "c", "D", "E", "H", "M", "Z", "7", "8", ">", "=": begin
            item_out.esc_final = 1'b1;
            item_out.esc_op    = aesp_pkg::ESC_CLOSE;
         end
         default: begin
            item_out.esc_final = 1'b0;
         end
      endcase

      // CSI finals
      case (byte_in)
         "A", "B", "C", "D", "G", "H", "J", "K", "P", "c", "d", "m", "n": begin
            item_out.csi_final = 1'b1;
         end
         "h", "l": begin
            item_out.csi_final  = 1'b1;
            item_out.mode_final = 1'b1;
         end
         default: begin
            item_out.csi_final = 1'b0;
         end
      endcase

      item_out.question  = (byte_in == aesp_pkg::CH_QUES);
      item_out.semi      = (byte_in == aesp_pkg::CH_SEMI);
      item_out.digit     = (byte_in >= aesp_pkg::CH_ZERO) && (byte_in <= aesp_pkg::CH_NINE);
      item_out.digit_val = byte_in[3:0];
   end

endmodule

`default_nettype wire

// File: src/aesp_queue.sv
// Short queue of classified bytes between front and back ends.
// Depends on aesp_pkg.
`default_nettype none

module aesp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire aesp_pkg::item_type push_item,
   output logic                    can_push,
   input  wire logic               pop,
   output logic                    head_valid,
   output aesp_pkg::item_type      head_item
);

   aesp_pkg::item_type                  slot_ff [aesp_pkg::QUEUE_DEPTH];
   logic [aesp_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [aesp_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [aesp_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                                do_push, do_pop;

   assign can_push   = (count_ff != aesp_pkg::QCNT_W'(aesp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && can_push;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == aesp_pkg::QPTR_W'(aesp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == aesp_pkg::QPTR_W'(aesp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: src/aesp_back.sv
// Back end: parser state, parameter collection and the result register.
// Depends on aesp_pkg.
`default_nettype none

module aesp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire aesp_pkg::item_type head_item,
   output logic                    pop,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output aesp_pkg::result_type    out_result
);

   // parser state
   logic                               in_escape_ff, in_escape_in;
   logic                               in_csi_ff, in_csi_in;
   logic                               private_ff, private_in;
   logic                               skip_ff, skip_in;
   logic                               prev_digit_ff, prev_digit_in;
   logic [aesp_pkg::PARAM_BITS-1:0]    accum_ff, accum_in;
   logic [aesp_pkg::CNT_W-1:0]         held_ff, held_in;
   logic [aesp_pkg::PARAM_BITS-1:0]    store_ff [aesp_pkg::MAX_PARAMS];
   logic [aesp_pkg::PARAM_BITS-1:0]    store_in [aesp_pkg::MAX_PARAMS];

   // result register
   logic                               out_valid_ff, out_valid_in;
   aesp_pkg::result_type               result_ff, result_in;

   logic [aesp_pkg::ACC_W-1:0]         acc_next;
   logic                               store_now;
   aesp_pkg::item_type                 it;

   assign it        = head_item;
   assign pop       = head_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_result = result_ff;

   // times ten plus digit, saturated
   always_comb begin
      acc_next = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0} +
                 {{(aesp_pkg::ACC_W-4){1'b0}}, it.digit_val};
   end

   // parser step for the head item
   always_comb begin
      in_escape_in  = in_escape_ff;
      in_csi_in     = in_csi_ff;
      private_in    = private_ff;
      skip_in       = skip_ff;
      prev_digit_in = prev_digit_ff;
      accum_in      = accum_ff;
      held_in       = held_ff;
      store_now     = 1'b0;
      for (int j = 0; j < aesp_pkg::MAX_PARAMS; j++) begin
         store_in[j] = store_ff[j];
      end
      result_in        = '0;
      result_in.data   = it.data;
      result_in.action = aesp_pkg::ACT_NONE;

      if (skip_ff) begin
         in_escape_in = 1'b0;
         skip_in      = 1'b0;
      end else if (!in_csi_ff && !in_escape_ff && it.ctrl) begin
         if (it.csi_intro) begin
            in_csi_in     = 1'b1;
            in_escape_in  = 1'b0;
            private_in    = 1'b0;
            held_in       = '0;
            accum_in      = '0;
            prev_digit_in = 1'b0;
         end else if (it.esc) begin
            in_escape_in = 1'b1;
         end else begin
            result_in.action = it.ctrl_action;
         end
      end else if (in_escape_ff && it.esc_final) begin
         case (it.esc_op)
            aesp_pkg::ESC_OPEN_CSI: begin
               in_csi_in     = 1'b1;
               in_escape_in  = 1'b0;
               private_in    = 1'b0;
               held_in       = '0;
               accum_in      = '0;
               prev_digit_in = 1'b0;
            end
            aesp_pkg::ESC_SKIP: begin
               skip_in = 1'b1;
            end
            aesp_pkg::ESC_OSC: begin
               in_escape_in = 1'b0;
            end
            default: begin
               accum_in       = '0;
               in_csi_in      = 1'b0;
               in_escape_in   = 1'b0;
               prev_digit_in  = 1'b0;
               result_in.show = 1'b1;
            end
         endcase
      end else if (in_csi_ff) begin
         if (it.csi_final || it.semi) begin
            // store a pending number
            if (prev_digit_ff) begin
               store_now = 1'b1;
               accum_in  = '0;
               if (held_ff < aesp_pkg::CNT_W'(aesp_pkg::MAX_PARAMS)) begin
                  store_in[held_ff[aesp_pkg::IDX_W-1:0]] = accum_ff;
                  held_in = held_ff + 1'b1;
               end
            end
            prev_digit_in = 1'b0;
            if (it.csi_final) begin
               accum_in     = '0;
               in_csi_in    = 1'b0;
               in_escape_in = 1'b0;
               if (!it.mode_final || private_ff) begin
                  result_in.action       = aesp_pkg::ACT_CSI;
                  result_in.final_code   = it.data;
                  result_in.private_mode = private_ff;
                  result_in.param_count  = aesp_pkg::COUNT_BITS'(held_in);
                  for (int j = 0; j < aesp_pkg::RSP_PARAMS; j++) begin
                     if (aesp_pkg::CNT_W'(j) < held_in) begin
                        result_in.params[j] = store_in[j];
                     end
                  end
               end
            end
         end else if (it.question) begin
            private_in    = 1'b1;
            prev_digit_in = 1'b0;
         end else if (it.digit) begin
            accum_in = (acc_next[aesp_pkg::ACC_W-1:aesp_pkg::PARAM_BITS] != '0) ?
                       '1 : acc_next[aesp_pkg::PARAM_BITS-1:0];
            prev_digit_in = 1'b1;
         end else begin
            accum_in       = '0;
            in_csi_in      = 1'b0;
            in_escape_in   = 1'b0;
            prev_digit_in  = 1'b0;
            result_in.show = 1'b1;
         end
      end else begin
         if (in_escape_ff && it.esc) begin
            in_escape_in     = 1'b0;
            result_in.action = aesp_pkg::ACT_ESC_ESC;
         end
         result_in.show = 1'b1;
      end
   end

   // output beat holds until taken
   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_escape_ff  <= 1'b0;
         in_csi_ff     <= 1'b0;
         private_ff    <= 1'b0;
         skip_ff       <= 1'b0;
         prev_digit_ff <= 1'b0;
         accum_ff      <= '0;
         held_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            in_escape_ff  <= in_escape_in;
            in_csi_ff     <= in_csi_in;
            private_ff    <= private_in;
            skip_ff       <= skip_in;
            prev_digit_ff <= prev_digit_in;
            accum_ff      <= accum_in;
            held_ff       <= held_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
         if (store_now) begin
            for (int j = 0; j < aesp_pkg::MAX_PARAMS; j++) begin
               store_ff[j] <= store_in[j];
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: src/ansi_escape_sequence_parser.sv
// Path: an accepted byte is written into the queue, then the parser step registers its result beat.
// Throughput: one byte per cycle, sustained while the result side takes a beat per cycle;
//   set by the two-entry queue between the classifier and the parser step.
// Reset is synchronous: it clears the parser state, the queue and the result valid.
// The parameter store holds no reset value; entries are read only after being written.
`default_nettype none

module ansi_escape_sequence_parser (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,  // byte_in
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // byte_out[7:0], final_code[15:8], private_mode[16], param_count[19:17],
   // param_first[35:20], param_second[51:36], param_third[67:52],
   // param_fourth[83:68], zero pad above
   output logic [aesp_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // show[0], action_kind[4:1]
   output logic [aesp_pkg::RSP_USER_W-1:0]          rsp_tuser
);

   aesp_pkg::item_type     front_item;
   aesp_pkg::item_type     head_item;
   aesp_pkg::result_type   result;
   logic                   head_valid;
   logic                   pop;

   aesp_front u_front (
      .byte_in  (req_tdata),
      .item_out (front_item)
   );

   aesp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_item  (front_item),
      .can_push   (req_tready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   aesp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // pack the result beat
   assign rsp_tdata = {
      {(aesp_pkg::RSP_DATA_W - aesp_pkg::RSP_FIELD_BITS){1'b0}},
      result.params,
      result.param_count,
      result.private_mode,
      result.final_code,
      result.data
   };
   assign rsp_tuser = {result.action, result.show};

`ifndef NO_ASSERTIONS
   // only a CSI command carries a final code or parameters
   a_fields_only_on_csi: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (result.action != aesp_pkg::ACT_CSI) |->
         (result.final_code == '0) && (result.param_count == '0) && !result.private_mode)
      else $error("command fields set without a CSI action");

   // parameter count never exceeds the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result.param_count <= aesp_pkg::COUNT_BITS'(aesp_pkg::MAX_PARAMS)))
      else $error("parameter count beyond store depth");

   // a shown byte carries no action other than ESC ESC
   a_show_action: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.show |->
         (result.action == aesp_pkg::ACT_NONE) || (result.action == aesp_pkg::ACT_ESC_ESC))
      else $error("shown byte with a control action");

   // a new result beat always comes from a queued byte
   a_beat_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(head_valid))
      else $error("result beat without a queued byte");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking bench for the escape sequence parser: a queue-fed byte driver, a
// result monitor with a built-in byte-by-byte parser predictor, random idling on both sides.
// Depends on aesp_pkg and ansi_escape_sequence_parser.
`timescale 1ns / 100ps

module tb_top;

   localparam int SEND_BYTES     = 1350;
   localparam int IDLE_LIMIT     = 2000;
   localparam int TAIL_CYCLES    = 10;
   localparam int SMOKE_LEN      = 27;
   localparam int unsigned ACC_MAX = (1 << aesp_pkg::PARAM_BITS) - 1;

   // Short directed run: edge bytes, all idle controls, ESC ESC, charset drop,
   // private CSI with saturation, an empty parameter and a mode final
   localparam logic [8*SMOKE_LEN-1:0] SMOKE_SEQ = {
      8'h00, 8'hFF, aesp_pkg::CH_BEL, aesp_pkg::CH_BS, aesp_pkg::CH_HT, aesp_pkg::CH_LF,
      aesp_pkg::CH_CR, aesp_pkg::CH_DEL, aesp_pkg::CH_SO, aesp_pkg::CH_SI, aesp_pkg::CH_CAN,
      aesp_pkg::CH_ESC, aesp_pkg::CH_ESC, aesp_pkg::CH_ESC, "(", "A",
      aesp_pkg::CH_CSI, aesp_pkg::CH_QUES, "99999", aesp_pkg::CH_SEMI, aesp_pkg::CH_SEMI,
      "1", "h"};
   localparam logic [8*15-1:0] CSI_ENDS = "ABCDGHJKPcdmnhl";
   localparam logic [8*15-1:0] ESC_ENDS = "cDEHMZ78>=]%#()";
   localparam logic [8*9-1:0]  CTRL_SET = {
      aesp_pkg::CH_BEL, aesp_pkg::CH_BS, aesp_pkg::CH_HT, aesp_pkg::CH_LF, aesp_pkg::CH_CR,
      aesp_pkg::CH_DEL, aesp_pkg::CH_SO, aesp_pkg::CH_SI, aesp_pkg::CH_CAN};

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata  = 8'h00;  // byte_in
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // byte_out, final_code, private_mode, param_count, param_first..param_fourth
   logic [aesp_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   // show, action_kind
   logic [aesp_pkg::RSP_USER_W-1:0]   rsp_tuser;

   ansi_escape_sequence_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Stimulus and expected results
   logic [7:0]            byte_queue [$];
   aesp_pkg::result_type  expected_rsp [$];
   int                    accepted_bytes = 0;
   int                    fail_count     = 0;
   int                    idle_cycles    = 0;
   int                    send_gap       = 0;
   int                    recv_gap       = 0;
   bit                    calm_send      = 1'b0;
   bit                    calm_recv      = 1'b0;

   // Predictor state, cleared as after reset
   logic                            esc_open   = 1'b0;
   logic                            csi_open   = 1'b0;
   logic                            priv_seen  = 1'b0;
   logic                            drop_next  = 1'b0;
   logic                            last_digit = 1'b0;
   int unsigned                     num_acc    = 0;
   int unsigned                     n_params   = 0;
   logic [aesp_pkg::PARAM_BITS-1:0] param_vals [aesp_pkg::MAX_PARAMS];

   function automatic int pick_gap(bit calm);
      int unsigned r;
      r = $urandom_range(99, 0);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function void start_csi();
      csi_open   = 1'b1;
      esc_open   = 1'b0;
      priv_seen  = 1'b0;
      n_params   = 0;
      num_acc    = 0;
      last_digit = 1'b0;
   endfunction

   function void end_seq();
      num_acc    = 0;
      csi_open   = 1'b0;
      esc_open   = 1'b0;
      last_digit = 1'b0;
   endfunction

   // A pending number is kept only when the last CSI byte was a digit
   function void push_number();
      if (last_digit) begin
         if (n_params < aesp_pkg::MAX_PARAMS) begin
            param_vals[n_params] = num_acc[aesp_pkg::PARAM_BITS-1:0];
            n_params++;
         end
         num_acc = 0;
      end
   endfunction

   // Advance the parser by one byte and return the result it reports
   function automatic aesp_pkg::result_type parse_byte(logic [7:0] c);
      aesp_pkg::result_type r;
      logic                 ctrl_hit;
      logic                 esc_hit;
      logic                 csi_hit;
      r      = '0;
      r.data = c;
      case (c)
         aesp_pkg::CH_BEL, aesp_pkg::CH_BS, aesp_pkg::CH_HT, aesp_pkg::CH_LF,
         aesp_pkg::CH_CR, aesp_pkg::CH_SO, aesp_pkg::CH_SI, aesp_pkg::CH_CAN,
         aesp_pkg::CH_ESC, aesp_pkg::CH_DEL, aesp_pkg::CH_CSI: ctrl_hit = 1'b1;
         default: ctrl_hit = 1'b0;
      endcase
      case (c)
         "c", "D", "E", "H", "M", "Z", "7", "8", "[", ">", "=", "]",
         "%", "#", "(", ")": esc_hit = 1'b1;
         default: esc_hit = 1'b0;
      endcase
      case (c)
         "A", "B", "C", "D", "G", "H", "J", "K", "P", "c", "d", "m", "n",
         "h", "l": csi_hit = 1'b1;
         default: csi_hit = 1'b0;
      endcase

      if (drop_next) begin
         esc_open  = 1'b0;
         drop_next = 1'b0;
      end else if (!csi_open && !esc_open && ctrl_hit) begin
         case (c)
            aesp_pkg::CH_CSI: start_csi();
            aesp_pkg::CH_ESC: esc_open = 1'b1;
            aesp_pkg::CH_BEL: r.action = aesp_pkg::ACT_BEEP;
            aesp_pkg::CH_BS:  r.action = aesp_pkg::ACT_BACKSPACE;
            aesp_pkg::CH_HT:  r.action = aesp_pkg::ACT_TAB;
            aesp_pkg::CH_LF:  r.action = aesp_pkg::ACT_LF;
            aesp_pkg::CH_CR:  r.action = aesp_pkg::ACT_CR;
            aesp_pkg::CH_DEL: r.action = aesp_pkg::ACT_DEL;
            default: ;
         endcase
      end else if (esc_open && esc_hit) begin
         if (c == "[")
            start_csi();
         else if (c == "%" || c == "(" || c == ")" || c == "#")
            drop_next = 1'b1;
         else if (c == "]")
            esc_open = 1'b0;
         else begin
            end_seq();
            r.show = 1'b1;
         end
      end else if (csi_open) begin
         if (csi_hit) begin
            push_number();
            // h and l only count as commands with the private marker
            if ((c != "h" && c != "l") || priv_seen) begin
               r.action       = aesp_pkg::ACT_CSI;
               r.final_code   = c;
               r.private_mode = priv_seen;
               r.param_count  = aesp_pkg::COUNT_BITS'(n_params);
               for (int j = 0; j < aesp_pkg::RSP_PARAMS && j < aesp_pkg::MAX_PARAMS; j++)
                  if (j < n_params)
                     r.params[j] = param_vals[j];
            end
            end_seq();
         end else if (c == aesp_pkg::CH_QUES) begin
            priv_seen  = 1'b1;
            last_digit = 1'b0;
         end else if (c == aesp_pkg::CH_SEMI) begin
            push_number();
            last_digit = 1'b0;
         end else if (c >= aesp_pkg::CH_ZERO && c <= aesp_pkg::CH_NINE) begin
            num_acc = num_acc * 10 + (c - aesp_pkg::CH_ZERO);
            if (num_acc > ACC_MAX)
               num_acc = ACC_MAX;
            last_digit = 1'b1;
         end else begin
            end_seq();
            r.show = 1'b1;
         end
      end else begin
         if (esc_open && c == aesp_pkg::CH_ESC) begin
            esc_open = 1'b0;
            r.action = aesp_pkg::ACT_ESC_ESC;
         end
         r.show = 1'b1;
      end
      return r;
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Byte driver: one beat from the queue, then a random gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(parse_byte(req_tdata));
            accepted_bytes <= accepted_bytes + 1;
            if ($urandom_range(199, 0) == 0)
               calm_send <= !calm_send;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               req_tdata  <= byte_queue.pop_front();
               req_tvalid <= 1'b1;
               send_gap   <= pick_gap(calm_send);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin : result_mon
      aesp_pkg::result_type want;
      string                pname [aesp_pkg::RSP_PARAMS];
      pname = '{"param_first", "param_second", "param_third", "param_fourth"};
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $error("result beat with no byte outstanding: tdata 0x%0h tuser 0x%0h",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("show", want.show, rsp_tuser[0]);
               check_field("action_kind", want.action, rsp_tuser[4:1]);
               check_field("byte_out", want.data, rsp_tdata[7:0]);
               check_field("final_code", want.final_code, rsp_tdata[15:8]);
               check_field("private_mode", want.private_mode, rsp_tdata[16]);
               check_field("param_count", want.param_count, rsp_tdata[19:17]);
               for (int j = 0; j < aesp_pkg::RSP_PARAMS; j++)
                  check_field(pname[j], want.params[j],
                              rsp_tdata[20 + aesp_pkg::PARAM_BITS*j +: aesp_pkg::PARAM_BITS]);
            end
         end
         if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap   <= pick_gap(calm_recv);
         end
         if ($urandom_range(299, 0) == 0)
            calm_recv <= !calm_recv;
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Stimulus build, reset, and end of run
   initial begin
      int unsigned pick;
      int unsigned n_num;
      int unsigned n_dig;
      int          total;
      logic [7:0]  b;

      for (int k = SMOKE_LEN - 1; k >= 0; k--)
         byte_queue.push_back(SMOKE_SEQ[8*k +: 8]);

      while (byte_queue.size() < SEND_BYTES) begin
         pick = $urandom_range(99, 0);
         if (pick < 40) begin
            // CSI sequence with random parameters
            if ($urandom_range(1, 0)) begin
               byte_queue.push_back(aesp_pkg::CH_CSI);
            end else begin
               byte_queue.push_back(aesp_pkg::CH_ESC);
               byte_queue.push_back("[");
            end
            if ($urandom_range(3, 0) == 0)
               byte_queue.push_back(aesp_pkg::CH_QUES);
            n_num = ($urandom_range(9, 0) == 0) ? $urandom_range(7, 4) :
                    $urandom_range(3, 0);
            for (int k = 0; k < n_num; k++) begin
               pick  = $urandom_range(9, 0);
               n_dig = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(8, 5) :
                       $urandom_range(3, 1);
               for (int d = 0; d < n_dig; d++)
                  byte_queue.push_back(aesp_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
               if ($urandom_range(19, 0) == 0)
                  byte_queue.push_back($urandom_range(1, 0) ? aesp_pkg::CH_QUES :
                                       8'($urandom_range(255, 0)));
               if (k < n_num - 1)
                  byte_queue.push_back(aesp_pkg::CH_SEMI);
            end
            if ($urandom_range(6, 0) == 0)
               byte_queue.push_back(8'($urandom_range(255, 0)));
            else
               byte_queue.push_back(CSI_ENDS[8*$urandom_range(14, 0) +: 8]);
         end else if (pick < 55) begin
            // ESC followed by a final or a random byte, with the dropped byte after a charset select
            byte_queue.push_back(aesp_pkg::CH_ESC);
            if ($urandom_range(9, 0) < 7) begin
               b = ESC_ENDS[8*$urandom_range(14, 0) +: 8];
               byte_queue.push_back(b);
               if (b == "%" || b == "#" || b == "(" || b == ")")
                  byte_queue.push_back(8'($urandom_range(255, 0)));
            end else begin
               byte_queue.push_back(8'($urandom_range(255, 0)));
            end
         end else if (pick < 65) begin
            byte_queue.push_back(CTRL_SET[8*$urandom_range(8, 0) +: 8]);
         end else if (pick < 85) begin
            byte_queue.push_back(8'($urandom_range(126, 32)));
         end else begin
            byte_queue.push_back(8'($urandom_range(255, 0)));
         end
      end
      total = byte_queue.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_bytes < total)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
